// File: rtl/core/sct_pkg.sv
// Package for the source character tokenizer: transfer payload types,
// result kinds, error codes and character constants.
// No dependencies.
package sct_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_stream;
  } char_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] value;
    logic [2:0]  error_code;
    logic        last;
  } token_t;

  localparam logic [2:0] KIND_INT   = 3'd0;
  localparam logic [2:0] KIND_ICHAR = 3'd1;
  localparam logic [2:0] KIND_IEND  = 3'd2;
  localparam logic [2:0] KIND_SEND  = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_BAD_INT   = 3'd1;
  localparam logic [2:0] ERR_TRUNCATED = 3'd2;
  localparam logic [2:0] ERR_BAD_ESC   = 3'd3;
  localparam logic [2:0] ERR_MALFORMED = 3'd4;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd5;

  localparam logic [7:0] CH_ZERO       = 8'h30;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
  localparam logic [7:0] CH_QUOTE      = 8'h27;
  localparam logic [7:0] CH_DQUOTE     = 8'h22;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

endpackage

// File: rtl/core/source_char_tokenizer_top.sv
// Top level of the source character tokenizer: lexer state, token logic and
// a four-entry result queue.
// Depends on sct_pkg.
//
//   Channel  Signals                            Payload
//   -------  ---------------------------------  -------------------------------
//   char     char_valid, char_ready, char_data  sct_pkg::char_t, one byte or EOS
//   tok      tok_valid, tok_ready, tok_data     sct_pkg::token_t, 0 to 2 per item
//
// One character is taken per cycle while char_ready is high; its results enter the
// queue at that edge. The queue gives one result per cycle while tok_ready is high,
// so two results of one item leave as two transfers. char_ready is high while the
// queue has room for two results. Reset clears the lexer state and empties the queue.
module source_char_tokenizer_top (
  input  logic            clk,
  input  logic            rst,
  input  logic            char_valid,
  output logic            char_ready,
  input  sct_pkg::char_t  char_data,
  output logic            tok_valid,
  input  logic            tok_ready,
  output sct_pkg::token_t tok_data
);

  localparam logic [2:0] MODE_IDLE  = 3'd0;
  localparam logic [2:0] MODE_INT   = 3'd1;
  localparam logic [2:0] MODE_IDENT = 3'd2;
  localparam logic [2:0] MODE_Q1    = 3'd3;
  localparam logic [2:0] MODE_Q2    = 3'd4;
  localparam logic [2:0] MODE_Q3    = 3'd5;
  localparam logic [2:0] MODE_ERR   = 3'd6;

  logic [2:0]  mode, mode_next;
  logic [63:0] acc, acc_next;
  logic [7:0]  first, first_next;
  logic [7:0]  second, second_next;

  sct_pkg::token_t res0, res1, st_res;
  logic [1:0]  n_res;
  logic        do_start, st_emit;
  logic [7:0]  c, digit;
  logic [63:0] esc_val;
  logic        esc_ok;

  sct_pkg::token_t queue [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       accept, pop;

  assign c      = char_data.ch;
  assign digit  = c - sct_pkg::CH_ZERO;
  assign accept = char_valid && char_ready;
  assign pop    = tok_valid && tok_ready;

  always_comb begin
    esc_ok  = 1'b1;
    esc_val = '0;
    case (second)
      8'h30:                 esc_val = 64'd0;
      8'h6E:                 esc_val = 64'd10;
      8'h74:                 esc_val = 64'd9;
      8'h72:                 esc_val = 64'd13;
      sct_pkg::CH_QUOTE:     esc_val = 64'd39;
      sct_pkg::CH_DQUOTE:    esc_val = 64'd34;
      sct_pkg::CH_BACKSLASH: esc_val = 64'd92;
      default:               esc_ok  = 1'b0;
    endcase
  end

  always_comb begin
    mode_next   = mode;
    acc_next    = acc;
    first_next  = first;
    second_next = second;
    res0        = '0;
    res1        = '0;
    st_res      = '0;
    n_res       = 2'd0;
    do_start    = 1'b0;
    st_emit     = 1'b0;
    if (char_data.end_of_stream) begin
      case (mode)
        MODE_INT: begin
          res0.kind  = sct_pkg::KIND_INT;
          res0.value = acc;
          n_res      = 2'd1;
        end
        MODE_IDENT: begin
          res0.kind = sct_pkg::KIND_IEND;
          n_res     = 2'd1;
        end
        MODE_Q1, MODE_Q2: begin
          res0.kind       = sct_pkg::KIND_ERR;
          res0.error_code = sct_pkg::ERR_TRUNCATED;
          n_res           = 2'd1;
        end
        MODE_Q3: begin
          if (second == sct_pkg::CH_QUOTE) begin
            res0.kind  = sct_pkg::KIND_INT;
            res0.value = {56'd0, first};
          end else begin
            res0.kind       = sct_pkg::KIND_ERR;
            res0.error_code = sct_pkg::ERR_MALFORMED;
          end
          n_res = 2'd1;
        end
        default: ;
      endcase
      if (n_res == 2'd0) begin
        res0.kind = sct_pkg::KIND_SEND;
      end else begin
        res1.kind = sct_pkg::KIND_SEND;
      end
      n_res       = n_res + 2'd1;
      mode_next   = MODE_IDLE;
      acc_next    = '0;
      first_next  = '0;
      second_next = '0;
    end else begin
      case (mode)
        MODE_IDLE: do_start = 1'b1;
        MODE_INT: begin
          if (sct_pkg::is_dig(c)) begin
            acc_next = {acc[60:0], 3'b000} + {acc[62:0], 1'b0} + {56'd0, digit};
          end else if (c == sct_pkg::CH_UNDERSCORE) begin
            acc_next = acc;
          end else if (sct_pkg::is_ws(c)) begin
            res0.kind  = sct_pkg::KIND_INT;
            res0.value = acc;
            n_res      = 2'd1;
            mode_next  = MODE_IDLE;
          end else begin
            res0.kind       = sct_pkg::KIND_ERR;
            res0.error_code = sct_pkg::ERR_BAD_INT;
            n_res           = 2'd1;
            mode_next       = MODE_ERR;
          end
        end
        MODE_IDENT: begin
          if (sct_pkg::is_alpha(c) || sct_pkg::is_dig(c)) begin
            res0.kind  = sct_pkg::KIND_ICHAR;
            res0.value = {56'd0, c};
          end else begin
            res0.kind = sct_pkg::KIND_IEND;
            do_start  = 1'b1;
          end
          n_res = 2'd1;
        end
        MODE_Q1: begin
          first_next = c;
          mode_next  = MODE_Q2;
        end
        MODE_Q2: begin
          second_next = c;
          mode_next   = MODE_Q3;
        end
        MODE_Q3: begin
          n_res = 2'd1;
          if (first == sct_pkg::CH_BACKSLASH && c == sct_pkg::CH_QUOTE) begin
            if (esc_ok) begin
              res0.kind  = sct_pkg::KIND_INT;
              res0.value = esc_val;
              mode_next  = MODE_IDLE;
            end else begin
              res0.kind       = sct_pkg::KIND_ERR;
              res0.error_code = sct_pkg::ERR_BAD_ESC;
              mode_next       = MODE_ERR;
            end
          end else if (second == sct_pkg::CH_QUOTE) begin
            res0.kind  = sct_pkg::KIND_INT;
            res0.value = {56'd0, first};
            do_start   = 1'b1;
          end else begin
            res0.kind       = sct_pkg::KIND_ERR;
            res0.error_code = sct_pkg::ERR_MALFORMED;
            mode_next       = MODE_ERR;
          end
        end
        default: mode_next = MODE_ERR;
      endcase
      if (do_start) begin
        if (sct_pkg::is_ws(c)) begin
          mode_next = MODE_IDLE;
        end else if (sct_pkg::is_dig(c)) begin
          mode_next = MODE_INT;
          acc_next  = {56'd0, digit};
        end else if (c == sct_pkg::CH_QUOTE) begin
          mode_next = MODE_Q1;
        end else if (sct_pkg::is_alpha(c)) begin
          mode_next    = MODE_IDENT;
          st_res.kind  = sct_pkg::KIND_ICHAR;
          st_res.value = {56'd0, c};
          st_emit      = 1'b1;
        end else begin
          mode_next         = MODE_ERR;
          st_res.kind       = sct_pkg::KIND_ERR;
          st_res.error_code = sct_pkg::ERR_BAD_CHAR;
          st_emit           = 1'b1;
        end
        if (st_emit) begin
          if (n_res == 2'd0) begin
            res0 = st_res;
          end else begin
            res1 = st_res;
          end
          n_res = n_res + 2'd1;
        end
      end
    end
    if (n_res == 2'd1) begin
      res0.last = 1'b1;
    end
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      acc    <= '0;
      first  <= '0;
      second <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      acc    <= acc_next;
      first  <= first_next;
      second <= second_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && n_res != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (accept && n_res == 2'd2) begin
      queue[wr_ptr + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + n_res;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      count <= count + (accept ? {1'b0, n_res} : 3'd0) - {2'b00, pop};
    end
  end

  assign char_ready = count <= 3'd2;
  assign tok_valid  = count != 3'd0;
  assign tok_data   = queue[rd_ptr];

endmodule
